### src/prsw_pkg.sv
package prsw_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned LimitWidth = 8;
  localparam int unsigned PermWidth  = 10;
  localparam int unsigned ProdWidth  = CountWidth + PermWidth;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = PermWidth;

  localparam logic [LimitWidth-1:0] MaxLossesReset   = LimitWidth'(5);
  localparam logic [PermWidth-1:0]  LossPermilleReset = PermWidth'(1);

  localparam logic [CfgIdxWidth-1:0] CFG_MAX_LOSSES   = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_LOSS_PERMILLE = 1'b1;

  typedef enum logic [1:0] {
    ACT_NEW     = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EV_SEND  = 3'd0,
    EV_RETX  = 3'd1,
    EV_SKIP  = 3'd2,
    EV_DELIV = 3'd3,
    EV_IGN   = 3'd4
  } event_e;

  typedef struct packed {
    logic [LimitWidth-1:0] max_losses;
    logic [PermWidth-1:0]  loss_permille;
  } cfg_t;

  typedef struct packed {
    event_e                event_res;
    logic                  seq_bit;
    logic [LimitWidth-1:0] consec_losses;
    logic [CountWidth-1:0] message_count;
    logic [CountWidth-1:0] skip_count;
    logic [CountWidth-1:0] send_count;
    logic [CountWidth-1:0] loss_count;
  } result_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
  endfunction

endpackage

### src/prsw_rate.sv
module prsw_rate import prsw_pkg::*; (
  input  logic [CountWidth-1:0] skips_i,
  input  logic [CountWidth-1:0] messages_i,
  input  logic [PermWidth-1:0]  loss_permille_i,
  output logic                  rate_reached_o
);

  logic [ProdWidth-1:0] skips_ext;
  logic [ProdWidth-1:0] skips_scaled;
  logic [ProdWidth-1:0] admitted;

  assign skips_ext = ProdWidth'(skips_i);

  // skips * 1000 as 1024 - 16 - 8
  assign skips_scaled = (skips_ext << 10) - (skips_ext << 4) - (skips_ext << 3);
  assign admitted     = ProdWidth'(messages_i) * ProdWidth'(loss_permille_i);

  assign rate_reached_o = (skips_scaled >= admitted);

endmodule

### src/prsw_core.sv
module prsw_core import prsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [1:0] action_i,
  input  logic       ack_bit_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  logic                  cur_seq_q, cur_seq_d;
  logic                  awaiting_q, awaiting_d;
  logic                  lost_q, lost_d;
  logic [LimitWidth-1:0] consec_q, consec_d, consec_inc;
  logic [CountWidth-1:0] messages_q, messages_d;
  logic [CountWidth-1:0] skips_q, skips_d;
  logic [CountWidth-1:0] sends_q, sends_d;
  logic [CountWidth-1:0] losses_q, losses_d;
  logic                  rate_reached;
  event_e                ev;

  prsw_rate u_rate (
    .skips_i        (skips_q),
    .messages_i     (messages_q),
    .loss_permille_i(cfg_i.loss_permille),
    .rate_reached_o (rate_reached)
  );

  assign consec_inc = (consec_q == {LimitWidth{1'b1}}) ? consec_q : consec_q + LimitWidth'(1);

  always_comb begin
    cur_seq_d  = cur_seq_q;
    awaiting_d = awaiting_q;
    lost_d     = lost_q;
    consec_d   = consec_q;
    messages_d = messages_q;
    skips_d    = skips_q;
    sends_d    = sends_q;
    losses_d   = losses_q;
    ev         = EV_IGN;
    case (action_i)
      ACT_NEW: begin
        if (!awaiting_q) begin
          awaiting_d = 1'b1;
          lost_d     = 1'b0;
          messages_d = sat_inc(messages_q);
          sends_d    = sat_inc(sends_q);
          ev         = EV_SEND;
        end
      end
      ACT_ACK: begin
        if (awaiting_q && (ack_bit_i == cur_seq_q)) begin
          // clear the loss run on a clean delivery or once past the limit
          if (!lost_q || (consec_q > cfg_i.max_losses)) begin
            consec_d = '0;
          end
          awaiting_d = 1'b0;
          cur_seq_d  = ~cur_seq_q;
          ev         = EV_DELIV;
        end
      end
      ACT_TIMEOUT: begin
        if (awaiting_q) begin
          lost_d   = 1'b1;
          losses_d = sat_inc(losses_q);
          consec_d = consec_inc;
          if (rate_reached || (consec_inc > cfg_i.max_losses)) begin
            sends_d = sat_inc(sends_q);
            ev      = EV_RETX;
          end else begin
            // abandon the message, keep the sequence bit
            skips_d    = sat_inc(skips_q);
            awaiting_d = 1'b0;
            ev         = EV_SKIP;
          end
        end
      end
      default: begin
        ev = EV_IGN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seq_q  <= 1'b0;
      awaiting_q <= 1'b0;
      lost_q     <= 1'b0;
      consec_q   <= '0;
      messages_q <= '0;
      skips_q    <= '0;
      sends_q    <= '0;
      losses_q   <= '0;
    end else if (fire_i) begin
      cur_seq_q  <= cur_seq_d;
      awaiting_q <= awaiting_d;
      lost_q     <= lost_d;
      consec_q   <= consec_d;
      messages_q <= messages_d;
      skips_q    <= skips_d;
      sends_q    <= sends_d;
      losses_q   <= losses_d;
    end
  end

  always_comb begin
    result_o.event_res     = ev;
    result_o.seq_bit       = cur_seq_q;
    result_o.consec_losses = consec_d;
    result_o.message_count = messages_d;
    result_o.skip_count    = skips_d;
    result_o.send_count    = sends_d;
    result_o.loss_count    = losses_d;
  end

endmodule

### src/partial_reliability_stop_and_wait_sender_unit.sv
// An accepted transaction is held in the input register, and its result in the result
// register. Throughput: one transaction per cycle unless out_ready_i stalls the output;
// the two registers let a new transaction enter while a finished result waits on out_ready_i.
// The rate test (one 32x10 multiply and a compare) runs from the counter registers.
// Reset (rst_ni low, asynchronous) clears all counters, the sequence bit and both
// valid flags, and loads the loss limit with 5 and the loss rate with 1 permille.
module partial_reliability_stop_and_wait_sender_unit import prsw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic                    ack_bit_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              event_res_o,
  output logic                    seq_bit_o,
  output logic [LimitWidth-1:0]   consec_losses_o,
  output logic [CountWidth-1:0]   message_count_o,
  output logic [CountWidth-1:0]   skip_count_o,
  output logic [CountWidth-1:0]   send_count_o,
  output logic [CountWidth-1:0]   loss_count_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [1:0] action_q;
  logic       ack_bit_q;
  logic       out_valid_q;
  result_t    result_q;
  result_t    result;
  logic       out_free;
  logic       fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_losses    <= MaxLossesReset;
      cfg_q.loss_permille <= LossPermilleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LOSSES:    cfg_q.max_losses    <= cfg_wdata_i[LimitWidth-1:0];
        CFG_LOSS_PERMILLE: cfg_q.loss_permille <= cfg_wdata_i[PermWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q  <= action_i;
      ack_bit_q <= ack_bit_i;
    end
  end

  prsw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .action_i (action_q),
    .ack_bit_i(ack_bit_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = result_q.event_res;
  assign seq_bit_o       = result_q.seq_bit;
  assign consec_losses_o = result_q.consec_losses;
  assign message_count_o = result_q.message_count;
  assign skip_count_o    = result_q.skip_count;
  assign send_count_o    = result_q.send_count;
  assign loss_count_o    = result_q.loss_count;

endmodule
